### hdl/lbrc_pkg.sv
// Shared constants and types for the LRU block read cache tag controller.
package lbrc_pkg;

    localparam int ENTRIES      = 8;
    localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W        = $clog2(ENTRIES + 1);
    localparam int BLK_SIZE     = 512;
    localparam int BYTES_W      = $clog2(BLK_SIZE + 1);
    localparam int FILE_ID_BITS = 16;
    localparam int SLOT_W       = 3;

    typedef enum logic [1:0] {
        CMD_CONSUME   = 2'd0,
        CMD_FILL      = 2'd1,
        CMD_FLUSH_ONE = 2'd2,
        CMD_FLUSH_ALL = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_FILLED  = 3'd2,
        ST_NODATA  = 3'd3,
        ST_DRVERR  = 3'd4,
        ST_FLUSHED = 3'd5
    } t_status;

    typedef struct packed {
        logic [FILE_ID_BITS-1:0] file;
        logic [31:0]             block;
        logic [BYTES_W-1:0]      bytes;
        logic [BYTES_W-1:0]      used;
        logic [31:0]             stamp;
    } t_entry;

endpackage

### hdl/lru_block_read_cache_tags.sv
// Tag controller: fully associative read-once block cache with LRU fill.
// Flush all answers in the cycle after accept; other commands scan the tags,
// one tag memory read per cycle, then a compare stage, then a write-back state
// that waits for the result register. One command is in flight at a time; the
// next is taken as the result word leaves.
// Reset (synchronous, active low) clears live bits, counters and stamp counter.
module lru_block_read_cache_tags (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_command,
    input  logic [lbrc_pkg::FILE_ID_BITS-1:0]  i_file_id,
    input  logic [31:0]                        i_block_index,
    input  logic [15:0]                        i_request_bytes,
    input  logic [9:0]                         i_fill_bytes,
    input  logic                               i_driver_error,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [2:0]                         o_status,
    output logic [2:0]                         o_slot,
    output logic [8:0]                         o_start_offset,
    output logic [9:0]                         o_take_bytes,
    output logic [31:0]                        o_hit_bytes,
    output logic [31:0]                        o_miss_count,
    output logic [31:0]                        o_fill_count,
    output logic [31:0]                        o_eviction_count
);
    import lbrc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} t_state;

    t_entry                  mem [ENTRIES];
    t_entry                  r_rd;
    logic [IDX_W-1:0]        ra;
    logic                    we;
    t_entry                  wd;

    t_state                  r_state;
    logic [ENTRIES-1:0]      r_live;
    logic [CNT_W-1:0]        r_ridx;
    logic                    r_pv;
    logic [IDX_W-1:0]        r_pidx;
    t_cmd                    r_cmd;
    logic [FILE_ID_BITS-1:0] r_fid;
    logic [31:0]             r_blk;
    logic [15:0]             r_req;
    logic [9:0]              r_fb;
    logic                    r_derr;
    logic                    r_found;
    logic                    r_have;
    logic [IDX_W-1:0]        r_sel;
    t_entry                  r_sel_e;
    logic [31:0]             r_sc;
    logic [31:0]             r_hb, r_mc, r_fc, r_ec;
    logic                    r_ov;
    logic [2:0]              r_st, r_slot;
    logic [8:0]              r_start;
    logic [9:0]              r_take;

    logic                    out_free;
    logic                    ov_set;
    logic [BYTES_W-1:0]      avail, take, n_used, fbs;
    logic [31:0]             n_sc;
    logic                    fill_ok;
    logic                    e_live, f_match, b_match;

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign ov_set   = (o_ready && i_valid && t_cmd'(i_command) == CMD_FLUSH_ALL)
                    || (r_state == S_WRITE && out_free);
    assign ra       = r_ridx[IDX_W-1:0];
    assign n_sc     = r_sc + 32'd1;
    assign avail    = r_sel_e.bytes - r_sel_e.used;
    assign take     = (r_req < 16'(avail)) ? BYTES_W'(r_req) : avail;
    assign n_used   = r_sel_e.used + take;
    assign fbs      = (r_fb > 10'(BLK_SIZE)) ? BYTES_W'(BLK_SIZE) : BYTES_W'(r_fb);
    assign fill_ok  = !r_derr && (fbs != '0);
    assign e_live   = r_live[r_pidx];
    assign f_match  = r_rd.file == r_fid;
    assign b_match  = r_rd.block == r_blk;

    always_comb begin
        we = 1'b0;
        wd = r_sel_e;
        if (r_state == S_WRITE && out_free) begin
            unique case (r_cmd)
                CMD_CONSUME: begin
                    we      = r_found;
                    wd.used = n_used;
                    wd.stamp = n_sc;
                end
                CMD_FILL: begin
                    we       = 1'b1;
                    wd.file  = r_fid;
                    wd.block = r_blk;
                    wd.bytes = fbs;
                    wd.used  = '0;
                    wd.stamp = n_sc;
                end
                default: we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_sel] <= wd;
        end
        r_rd <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_ov    <= 1'b0;
            r_sc    <= '0;
            r_hb    <= '0;
            r_mc    <= '0;
            r_fc    <= '0;
            r_ec    <= '0;
            r_pv    <= 1'b0;
            r_ridx  <= '0;
        end else begin
            if (ov_set) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_fid   <= i_file_id;
                        r_blk   <= i_block_index;
                        r_req   <= i_request_bytes;
                        r_fb    <= i_fill_bytes;
                        r_derr  <= i_driver_error;
                        r_found <= 1'b0;
                        r_have  <= 1'b0;
                        r_sel   <= '0;
                        r_ridx  <= '0;
                        r_pv    <= 1'b0;
                        if (t_cmd'(i_command) == CMD_FLUSH_ALL) begin
                            r_live  <= '0;
                            r_sc    <= '0;
                            r_hb    <= '0;
                            r_mc    <= '0;
                            r_fc    <= '0;
                            r_ec    <= '0;
                            r_st    <= ST_FLUSHED;
                            r_slot  <= '0;
                            r_start <= '0;
                            r_take  <= '0;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_ridx < CNT_W'(ENTRIES)) begin
                        r_pv   <= 1'b1;
                        r_pidx <= ra;
                        r_ridx <= r_ridx + CNT_W'(1);
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        unique case (r_cmd)
                            CMD_CONSUME: begin
                                if (!r_found && e_live && f_match && b_match) begin
                                    r_found <= 1'b1;
                                    r_sel   <= r_pidx;
                                    r_sel_e <= r_rd;
                                end
                            end
                            CMD_FILL: begin
                                if (!r_found) begin
                                    if (!e_live) begin
                                        r_found <= 1'b1;
                                        r_sel   <= r_pidx;
                                    end else if (!r_have || r_rd.stamp < r_sel_e.stamp) begin
                                        r_have  <= 1'b1;
                                        r_sel   <= r_pidx;
                                        r_sel_e <= r_rd;
                                    end
                                end
                            end
                            default: begin
                                if (e_live && f_match) begin
                                    r_live[r_pidx] <= 1'b0;
                                end
                            end
                        endcase
                        if (r_pidx == IDX_W'(ENTRIES - 1)) begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                default: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        unique case (r_cmd)
                            CMD_CONSUME: begin
                                if (r_found) begin
                                    r_st    <= ST_HIT;
                                    r_slot  <= SLOT_W'(r_sel);
                                    r_start <= 9'(r_sel_e.used);
                                    r_take  <= 10'(take);
                                    r_sc    <= n_sc;
                                    r_hb    <= r_hb + 32'(take);
                                    if (n_used == r_sel_e.bytes) begin
                                        r_live[r_sel] <= 1'b0;
                                    end
                                end else begin
                                    r_st    <= ST_MISS;
                                    r_slot  <= '0;
                                    r_start <= '0;
                                    r_take  <= '0;
                                end
                            end
                            CMD_FILL: begin
                                r_start       <= '0;
                                r_take        <= '0;
                                r_live[r_sel] <= fill_ok;
                                if (!r_found) begin
                                    r_ec <= r_ec + 32'd1;
                                end
                                if (r_derr) begin
                                    r_st   <= ST_DRVERR;
                                    r_slot <= '0;
                                end else if (!fill_ok) begin
                                    r_st   <= ST_NODATA;
                                    r_slot <= '0;
                                end else begin
                                    r_st   <= ST_FILLED;
                                    r_slot <= SLOT_W'(r_sel);
                                    r_sc   <= n_sc;
                                    r_fc   <= r_fc + 32'd1;
                                    r_mc   <= r_mc + 32'd1;
                                end
                            end
                            default: begin
                                r_st    <= ST_FLUSHED;
                                r_slot  <= '0;
                                r_start <= '0;
                                r_take  <= '0;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign o_valid          = r_ov;
    assign o_status         = r_st;
    assign o_slot           = r_slot;
    assign o_start_offset   = r_start;
    assign o_take_bytes     = r_take;
    assign o_hit_bytes      = r_hb;
    assign o_miss_count     = r_mc;
    assign o_fill_count     = r_fc;
    assign o_eviction_count = r_ec;

endmodule

### hdl/lbrc_checker.sv
// Port-level checker for the tag controller, bound to the top level.
module lbrc_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [2:0]  o_slot,
    input logic [8:0]  o_start_offset,
    input logic [9:0]  o_take_bytes
);
    import lbrc_pkg::*;

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_take_bytes))
        else $error("stalled result word changed");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_HIT && o_status != ST_FILLED |-> o_slot == '0)
        else $error("slot nonzero without hit or fill");

    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_HIT
        |-> 11'(o_start_offset) + 11'(o_take_bytes) <= 11'(BLK_SIZE))
        else $error("hit span exceeds block");

endmodule

bind lru_block_read_cache_tags lbrc_sva u_lbrc_sva (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_slot         (o_slot),
    .o_start_offset (o_start_offset),
    .o_take_bytes   (o_take_bytes)
);

### sim/lbrc_checker.sv
// Checker: predicts each result word of the cache tag controller and compares it.
module lbrc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [lbrc_pkg::FILE_ID_BITS-1:0] i_file_id,
    input  logic [31:0] i_block_index,
    input  logic [15:0] i_request_bytes,
    input  logic [9:0]  i_fill_bytes,
    input  logic        i_driver_error,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [2:0]  o_status,
    input  logic [2:0]  o_slot,
    input  logic [8:0]  o_start_offset,
    input  logic [9:0]  o_take_bytes,
    input  logic [31:0] o_hit_bytes,
    input  logic [31:0] o_miss_count,
    input  logic [31:0] o_fill_count,
    input  logic [31:0] o_eviction_count,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_hit_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lbrc_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [8:0]  start;
        logic [9:0]  take;
        logic [31:0] hit_bytes;
        logic [31:0] misses;
        logic [31:0] fills;
        logic [31:0] evictions;
    } t_answer;

    logic                    live  [ENTRIES];
    logic [FILE_ID_BITS-1:0] file  [ENTRIES];
    logic [31:0]             block [ENTRIES];
    logic [10:0]             bytes [ENTRIES];
    logic [10:0]             used  [ENTRIES];
    logic [31:0]             stamp [ENTRIES];
    logic [31:0]             stamp_now;
    logic [31:0]             hit_total, miss_total, fill_total, evict_total;
    t_answer                 answers[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic void drop_slot(int i);
        live[i] = 0; file[i] = '0; bytes[i] = '0; used[i] = '0;
    endfunction

    function automatic void clear_all();
        for (int i = 0; i < ENTRIES; i++) begin
            drop_slot(i); block[i] = '0; stamp[i] = '0;
        end
        stamp_now = 0; hit_total = 0; miss_total = 0; fill_total = 0; evict_total = 0;
    endfunction

    function automatic t_answer predict_cache(logic [1:0] cmd, logic [FILE_ID_BITS-1:0] fid,
            logic [31:0] blk, logic [15:0] req, logic [9:0] fb, logic derr);
        t_answer a;
        int      idx;
        logic [10:0] avail, take, fbytes;
        a = '0;
        a.status = ST_FLUSHED;
        idx = -1;
        unique case (t_cmd'(cmd))
            CMD_CONSUME: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (idx < 0 && live[i] && file[i] == fid && block[i] == blk
                            && used[i] < bytes[i])
                        idx = i;
                if (idx < 0) begin
                    a.status = ST_MISS;
                end else begin
                    avail = bytes[idx] - used[idx];
                    take = (req < avail) ? req[10:0] : avail;
                    a.status = ST_HIT;
                    a.slot = idx[2:0];
                    a.start = used[idx][8:0];
                    a.take = take[9:0];
                    used[idx] += take;
                    stamp_now++;
                    stamp[idx] = stamp_now;
                    if (used[idx] == bytes[idx]) drop_slot(idx);
                    hit_total += 32'(take);
                    o_hit_count++;
                end
            end
            CMD_FILL: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!live[i]) begin
                        idx = i;
                        break;
                    end
                    if (idx < 0 || stamp[i] < stamp[idx]) idx = i;
                end
                if (live[idx]) evict_total++;
                drop_slot(idx);
                block[idx] = blk;
                stamp[idx] = 0;
                fbytes = (fb > BLK_SIZE) ? 11'(BLK_SIZE) : {1'b0, fb};
                if (derr) begin
                    a.status = ST_DRVERR;
                end else if (fbytes == 0) begin
                    a.status = ST_NODATA;
                end else begin
                    live[idx] = 1; file[idx] = fid; bytes[idx] = fbytes; used[idx] = 0;
                    stamp_now++;
                    stamp[idx] = stamp_now;
                    fill_total++; miss_total++;
                    a.status = ST_FILLED;
                    a.slot = idx[2:0];
                end
            end
            CMD_FLUSH_ONE: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (live[i] && file[i] == fid) drop_slot(i);
            end
            default: clear_all();
        endcase
        a.hit_bytes = hit_total; a.misses = miss_total;
        a.fills = fill_total; a.evictions = evict_total;
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            clear_all();
            answers.delete();
        end else begin
            if (o_valid && i_ready) begin
                o_result_count++;
                if (answers.size() == 0) begin
                    report("unexpected word", {29'd0, o_status}, 32'd0);
                end else begin
                    want = answers.pop_front();
                    if (o_status != want.status)
                        report("status", 32'(o_status), 32'(want.status));
                    if (o_slot != want.slot)
                        report("slot", 32'(o_slot), 32'(want.slot));
                    if (o_start_offset != want.start)
                        report("start_offset", 32'(o_start_offset), 32'(want.start));
                    if (o_take_bytes != want.take)
                        report("take_bytes", 32'(o_take_bytes), 32'(want.take));
                    if (o_hit_bytes != want.hit_bytes)
                        report("hit_bytes", o_hit_bytes, want.hit_bytes);
                    if (o_miss_count != want.misses)
                        report("miss_count", o_miss_count, want.misses);
                    if (o_fill_count != want.fills)
                        report("fill_count", o_fill_count, want.fills);
                    if (o_eviction_count != want.evictions)
                        report("eviction_count", o_eviction_count, want.evictions);
                end
            end
            if (i_valid && o_ready)
                answers.push_back(predict_cache(i_command, i_file_id, i_block_index,
                    i_request_bytes, i_fill_bytes, i_driver_error));
        end
        o_pending = answers.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_result_count = 0;
        o_hit_count = 0;
    end
endmodule

### sim/tb.sv
// Testbench top: drives command words into the cache tag controller and gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lbrc_pkg::*;

    localparam int RANDOM_WORDS = 1250;
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_command = '0;
    logic [FILE_ID_BITS-1:0] i_file_id = '0;
    logic [31:0] i_block_index = '0;
    logic [15:0] i_request_bytes = '0;
    logic [9:0]  i_fill_bytes = '0;
    logic        i_driver_error = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_status, o_slot;
    logic [8:0]  o_start_offset;
    logic [9:0]  o_take_bytes;
    logic [31:0] o_hit_bytes, o_miss_count, o_fill_count, o_eviction_count;
    int          fail_count, pending, result_count, hit_count;
    int          cycles = 0;
    bit          sink_busy = 0;
    logic [FILE_ID_BITS-1:0] files[4];
    logic [31:0]             blocks[4];

    always #5 i_clk = ~i_clk;

    lru_block_read_cache_tags u_top (.*);

    lbrc_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command, .i_file_id, .i_block_index,
        .i_request_bytes, .i_fill_bytes, .i_driver_error, .o_valid, .i_ready,
        .o_status, .o_slot, .o_start_offset, .o_take_bytes, .o_hit_bytes,
        .o_miss_count, .o_fill_count, .o_eviction_count,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_hit_count(hit_count)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stall before each word, or none at random.
    always @(posedge i_clk) begin
        int wait_n;
        if (i_rst_n && !sink_busy) begin
            sink_busy = 1;
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_n > 0) begin
                i_ready <= 0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
            i_ready <= 0;
            sink_busy = 0;
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [FILE_ID_BITS-1:0] fid,
            logic [31:0] blk, logic [15:0] req, logic [9:0] fb, logic derr, bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_command <= cmd; i_file_id <= fid; i_block_index <= blk;
        i_request_bytes <= req; i_fill_bytes <= fb; i_driver_error <= derr;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random(bit calm);
        int k, r;
        logic [15:0] req;
        logic [9:0]  fb;
        k = $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        req = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
        fb = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(1, 300));
        if (r < 50)
            send_word(CMD_CONSUME, files[k], blocks[$urandom_range(0, 3)], req, fb,
                1'($urandom_range(0, 1)), calm);
        else if (r < 88)
            send_word(CMD_FILL, files[k], blocks[$urandom_range(0, 3)], req, fb,
                $urandom_range(0, 15) == 0, calm);
        else if (r < 93)
            send_word(CMD_CONSUME, 16'($urandom), $urandom, req, fb, 0, calm);
        else if (r < 98)
            send_word(CMD_FLUSH_ONE, files[k], $urandom, req, fb, 0, calm);
        else
            send_word(CMD_FLUSH_ALL, 16'($urandom), $urandom, req, fb, 0, calm);
    endtask

    initial begin
        bit calm;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every command and status, and eviction
        send_word(CMD_CONSUME, '0, '0, '0, '0, 0, 0);
        send_word(CMD_FILL, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 0, 0);
        send_word(CMD_CONSUME, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, '0, 0, 0);
        send_word(CMD_CONSUME, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '0, 1, 0);
        send_word(CMD_FILL, 16'd1, 32'd7, 0, 10'd0, 0, 0);
        send_word(CMD_FILL, 16'd1, 32'd7, 0, 10'd0, 1, 0);
        send_word(CMD_FILL, 16'd1, 32'd7, 0, 10'd512, 0, 0);
        send_word(CMD_FILL, 16'd1, 32'd7, 0, 10'd513, 0, 0);
        for (int i = 0; i < 7; i++)
            send_word(CMD_FILL, 16'd2, 32'(i), 0, 10'(i + 1), 0, 0);
        send_word(CMD_FILL, 16'd3, 32'd99, 0, 10'd10, 1, 0);
        send_word(CMD_CONSUME, 16'd1, 32'd7, 16'd100, 0, 0, 0);
        send_word(CMD_FILL, 16'd3, 32'd98, 0, 10'd1, 0, 0);
        send_word(CMD_FLUSH_ONE, 16'd2, 0, 0, 0, 0, 0);
        send_word(CMD_CONSUME, 16'd1, 32'd7, 16'd1000, 0, 0, 0);
        send_word(CMD_FLUSH_ALL, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 1, 0);
        send_word(CMD_CONSUME, 16'd1, 32'd7, 16'd5, 0, 0, 0);

        for (int w = 0; w < RANDOM_WORDS; w++) begin
            if (w % 200 == 0)
                for (int j = 0; j < 4; j++) begin
                    files[j] = ($urandom_range(0, 1)) ? 16'($urandom) : 16'(j);
                    blocks[j] = ($urandom_range(0, 1)) ? $urandom : 32'(j);
                end
            calm = (w % 150) >= 120;
            send_random(calm);
        end
        i_valid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("covered %0d result words, %0d hits, with random gaps and stalls",
            result_count, hit_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### files.f
hdl/lbrc_pkg.sv
hdl/lru_block_read_cache_tags.sv
hdl/lbrc_checker.sv
sim/lbrc_checker.sv
sim/tb.sv
